// ===== hw/rtl/lpht_pkg.sv =====
// lpht_pkg: shared types and constants for the linear-probe hash table
// used by linear_probe_hash_table and lpht_slot_ram; no dependencies
`default_nettype none

package lpht_pkg;

   localparam int SLOTS  = 4096;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int KEY_W  = 64;
   localparam int HANDLE_W = 16;

   localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOTS - 1);

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CLEAR,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } slot_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      slot_type         wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Linear-probe hash table of 4096 slots, each holding a 64-bit key, a 16-bit handle and an
// occupancy bit in a single-port-read synchronous memory. The home slot is the key's low 12
// bits. An insert or lookup is accepted in the idle state, the home slot is read at the
// accepting edge and then one slot is examined per cycle; the slot that ends the probe is
// held until the response output is free, and only then is the next request taken. A
// clear request sweeps every slot, one per cycle, and then answers. After reset the same
// sweep runs before the first request is accepted. A request of any other type is answered
// with both flags and the handle zero. Only one request is in flight.
// depends on lpht_pkg and lpht_slot_ram
`default_nettype none

module linear_probe_hash_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_type,
   input  wire logic [lpht_pkg::KEY_W-1:0]    req_key,
   input  wire logic [lpht_pkg::HANDLE_W-1:0] req_value_handle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_hit,
   output logic [lpht_pkg::HANDLE_W-1:0]      rsp_found_handle,
   output logic                               rsp_full_refused
);

   lpht_pkg::state_type state_ff, state_in;
   logic [lpht_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [lpht_pkg::IDX_W-1:0]    cnt_ff, cnt_in;
   logic [lpht_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lpht_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic [1:0]                    op_ff, op_in;
   logic                          init_ff, init_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [lpht_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                          rsp_full_ff, rsp_full_in;

   lpht_pkg::mem_req_type         mem_req;
   lpht_pkg::slot_type            slot;

   logic                          accept;
   logic                          out_free;
   logic                          is_ins;
   logic                          probe_hit;
   logic                          last_probe;
   logic                          term;
   logic                          rsp_load;
   logic [lpht_pkg::IDX_W-1:0]    idx_next;
   logic [lpht_pkg::IDX_W-1:0]    home;

   lpht_slot_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (slot)
   );

   assign req_ready = (state_ff == lpht_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign home      = req_key[lpht_pkg::IDX_W-1:0];
   assign idx_next  = (idx_ff == lpht_pkg::SLOT_LAST) ? '0 : idx_ff + 1'b1;

   // probe evaluation on the slot last read from the memory
   assign is_ins     = (op_ff == lpht_pkg::REQ_INSERT);
   assign probe_hit  = slot.valid && (slot.key == key_ff);
   assign last_probe = (cnt_ff == lpht_pkg::SLOT_LAST);
   assign term       = !slot.valid || (!is_ins && probe_hit) || last_probe;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpht_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type inside {lpht_pkg::REQ_INSERT, lpht_pkg::REQ_LOOKUP}) begin
                  state_in = lpht_pkg::ST_CHECK;
               end else if (req_type == lpht_pkg::REQ_CLEAR) begin
                  state_in = lpht_pkg::ST_CLEAR;
               end else begin
                  state_in = lpht_pkg::ST_DRAIN;
               end
            end
         end
         lpht_pkg::ST_CHECK: begin
            if (term && out_free) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         lpht_pkg::ST_CLEAR: begin
            if (idx_ff == lpht_pkg::SLOT_LAST) begin
               state_in = init_ff ? lpht_pkg::ST_IDLE : lpht_pkg::ST_DRAIN;
            end
         end
         lpht_pkg::ST_DRAIN: begin
            if (out_free) begin
               state_in = lpht_pkg::ST_IDLE;
            end
         end
         default: state_in = lpht_pkg::ST_IDLE;
      endcase
   end

   // memory control, probe registers and response loading
   always_comb begin
      mem_req       = '0;
      rsp_load      = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_full_in   = rsp_full_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      op_in         = op_ff;
      init_in       = init_ff;
      case (state_ff)
         lpht_pkg::ST_IDLE: begin
            if (accept) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = home;
               idx_in    = (req_type == lpht_pkg::REQ_CLEAR) ? '0 : home;
               cnt_in    = '0;
               key_in    = req_key;
               handle_in = req_value_handle;
               op_in     = req_type;
            end
         end
         lpht_pkg::ST_CHECK: begin
            if (term) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_hit_in    = !is_ins && probe_hit;
                  rsp_handle_in = (!is_ins && probe_hit) ? slot.handle : '0;
                  rsp_full_in   = is_ins && slot.valid;
                  if (is_ins && !slot.valid) begin
                     mem_req.wr_en          = 1'b1;
                     mem_req.wr_addr        = idx_ff;
                     mem_req.wr_data.valid  = 1'b1;
                     mem_req.wr_data.key    = key_ff;
                     mem_req.wr_data.handle = handle_ff;
                  end
               end
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_next;
               idx_in = idx_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lpht_pkg::ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            idx_in          = idx_next;
            if (idx_ff == lpht_pkg::SLOT_LAST) begin
               init_in = 1'b0;
            end
         end
         lpht_pkg::ST_DRAIN: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_handle_in = '0;
               rsp_full_in   = 1'b0;
            end
         end
         default: ;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || rsp_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_CLEAR;
         idx_ff       <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      op_ff         <= op_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_found_handle = rsp_handle_ff;
   assign rsp_full_refused = rsp_full_ff;

   // a transaction never reports both a hit and a refused insert
   a_hit_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_full_refused))
      else $error("hit and full_refused both set");

   // handle is zero unless the lookup hit
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_found_handle == '0))
      else $error("handle set on a miss");

   // an insert only ever fills a slot that was empty
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpht_pkg::ST_CHECK && mem_req.wr_en) |-> !slot.valid)
      else $error("insert overwrote an occupied slot");

   // the clearing sweep blocks requests right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (!req_ready && state_ff == lpht_pkg::ST_CLEAR))
      else $error("request accepted before the clearing sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/lpht_slot_ram.sv =====
// lpht_slot_ram: slot store, one write and one registered read port
// depends on lpht_pkg for the slot and request types
`default_nettype none

module lpht_slot_ram (
   input  wire logic                  clock,
   input  wire lpht_pkg::mem_req_type mem_req,
   output lpht_pkg::slot_type         rd_data
);

   lpht_pkg::slot_type mem [lpht_pkg::SLOTS];
   lpht_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sim/tb_linear_probe_hash_table.sv =====
// tb_linear_probe_hash_table: self-checking testbench for the linear-probe hash table
// drives insert, lookup, clear and unused-type transactions and checks them against a shadow table
// depends on lpht_pkg and linear_probe_hash_table
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;

   localparam logic [1:0] REQ_NOP = 2'd3;

   typedef struct packed {
      logic                          hit;
      logic [lpht_pkg::HANDLE_W-1:0] handle;
      logic                          full;
   } outcome_type;

   typedef struct {
      logic [1:0]                    op;
      logic [lpht_pkg::KEY_W-1:0]    key;
      logic [lpht_pkg::HANDLE_W-1:0] handle;
      bit                            typed;
      outcome_type                   want;
   } stim_row_type;

   localparam outcome_type OUT_ZERO = '0;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_type = REQ_NOP;
   logic [lpht_pkg::KEY_W-1:0]    req_key = '0;
   logic [lpht_pkg::HANDLE_W-1:0] req_value_handle = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_hit;
   logic [lpht_pkg::HANDLE_W-1:0] rsp_found_handle;
   logic                          rsp_full_refused;

   // shadow copy of the slot memory
   bit [lpht_pkg::KEY_W-1:0]    shadow_key[lpht_pkg::SLOTS];
   bit [lpht_pkg::HANDLE_W-1:0] shadow_handle[lpht_pkg::SLOTS];
   bit                          shadow_used[lpht_pkg::SLOTS];

   outcome_type                expected_outcomes[$];
   stim_row_type               directed_rows[$];
   logic [lpht_pkg::KEY_W-1:0] live_keys[$];

   int     snd_idle_pct = 0;
   int     rcv_idle_pct = 0;
   int     fail_count = 0;
   int     rsp_count = 0;
   longint cycle_count = 0;
   longint work_budget = 0;

   linear_probe_hash_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_key          (req_key),
      .req_value_handle (req_value_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_found_handle (rsp_found_handle),
      .rsp_full_refused (rsp_full_refused)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] transaction %0d %s: got %0h, expected %0h",
               $time, rsp_count, what, got, want);
      fail_count++;
   endtask

   // walks the probe path of the shadow table; probes gives the slots examined
   task automatic apply_to_shadow(input logic [1:0] op,
                                  input logic [lpht_pkg::KEY_W-1:0] key,
                                  input logic [lpht_pkg::HANDLE_W-1:0] handle,
                                  output outcome_type res, output int probes);
      int  slot;
      bit  done;
      res = OUT_ZERO;
      probes = 1;
      slot = int'(key % lpht_pkg::SLOTS);
      done = 1'b0;
      case (op)
         lpht_pkg::REQ_INSERT: begin
            res.full = 1'b1;
            probes = 0;
            while (!done && probes < lpht_pkg::SLOTS) begin
               probes++;
               if (!shadow_used[slot]) begin
                  shadow_key[slot] = key;
                  shadow_handle[slot] = handle;
                  shadow_used[slot] = 1'b1;
                  res.full = 1'b0;
                  done = 1'b1;
               end else begin
                  slot = (slot + 1) % lpht_pkg::SLOTS;
               end
            end
         end
         lpht_pkg::REQ_LOOKUP: begin
            probes = 0;
            while (!done && probes < lpht_pkg::SLOTS) begin
               probes++;
               if (!shadow_used[slot]) begin
                  done = 1'b1;
               end else if (shadow_key[slot] == key) begin
                  res.hit = 1'b1;
                  res.handle = shadow_handle[slot];
                  done = 1'b1;
               end else begin
                  slot = (slot + 1) % lpht_pkg::SLOTS;
               end
            end
         end
         lpht_pkg::REQ_CLEAR: begin
            foreach (shadow_used[i]) shadow_used[i] = 1'b0;
            probes = lpht_pkg::SLOTS;
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input logic [1:0] op, input logic [lpht_pkg::KEY_W-1:0] key,
                               input logic [lpht_pkg::HANDLE_W-1:0] handle, input bit typed,
                               input outcome_type want);
      outcome_type predicted;
      int          probes;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_key <= key;
      req_value_handle <= handle;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      apply_to_shadow(op, key, handle, predicted, probes);
      expected_outcomes.push_back(typed ? want : predicted);
      work_budget += 4 * (probes + 2) + 200;
   endtask

   // hold the request side off until every transaction has come back
   task automatic drain_requests();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input logic [1:0] op, input logic [lpht_pkg::KEY_W-1:0] key,
                          input logic [lpht_pkg::HANDLE_W-1:0] handle, input bit typed,
                          input outcome_type want);
      stim_row_type row;
      row.op = op;
      row.key = key;
      row.handle = handle;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // keys clustered on a window of 16 home slots, random upper bits
   function automatic logic [lpht_pkg::KEY_W-1:0] hot_key(input int base);
      logic [lpht_pkg::KEY_W-1:0] k;
      int                         h;
      k = {$urandom, $urandom};
      h = (base + int'($urandom_range(0, 15))) % lpht_pkg::SLOTS;
      k[lpht_pkg::IDX_W-1:0] = h[lpht_pkg::IDX_W-1:0];
      return k;
   endfunction

   task automatic check_response();
      outcome_type want;
      if (expected_outcomes.size() == 0) begin
         report_mismatch("unexpected transaction",
                         64'({rsp_hit, rsp_found_handle, rsp_full_refused}), 64'(0));
      end else begin
         want = expected_outcomes.pop_front();
         if (rsp_hit !== want.hit)
            report_mismatch("hit", 64'(rsp_hit), 64'(want.hit));
         if (rsp_found_handle !== want.handle)
            report_mismatch("found_handle", 64'(rsp_found_handle), 64'(want.handle));
         if (rsp_full_refused !== want.full)
            report_mismatch("full_refused", 64'(rsp_full_refused), 64'(want.full));
      end
      rsp_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         check_response();
      rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   // watchdog: allowance grows with the work of every accepted transaction
   initial begin
      while (cycle_count < 8 * (lpht_pkg::SLOTS + 1) + 2000 + work_budget) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [lpht_pkg::KEY_W-1:0] k;
      int                         n;
      int                         roll;
      int                         hot_base;
      hot_base = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 35;
      rcv_idle_pct = 74;

      add_row(lpht_pkg::REQ_LOOKUP, 64'h0, 16'h0, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, '1, 16'hFFFF, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_INSERT, 64'h0, 16'h0, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_INSERT, '1, 16'hFFFF, 1, OUT_ZERO);
      // same home as the all-ones key, wraps past the last slot
      add_row(lpht_pkg::REQ_INSERT, 64'h0000_0000_0000_0FFF, 16'h1234, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, 64'h0, 16'hFFFF, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, '1, 16'h0, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, 64'h0000_0000_0000_0FFF, 16'h0, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_INSERT, '1, 16'h5A5A, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, '1, 16'h0, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_INSERT, 64'hAAAA_AAAA_AAAA_A000, 16'h8001, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0FFF, 16'h0, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_A000, 16'h0, 0, OUT_ZERO);
      add_row(REQ_NOP, 64'hDEAD_BEEF_0000_0FFF, 16'hFFFF, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, 64'h0000_0000_0000_0FFF, 16'h0, 0, OUT_ZERO);
      add_row(lpht_pkg::REQ_CLEAR, '1, 16'hFFFF, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, '1, 16'h0, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, 64'h0, 16'h0, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_INSERT, 64'h5555_5555_5555_5555, 16'hAAAA, 1, OUT_ZERO);
      add_row(lpht_pkg::REQ_LOOKUP, 64'h5555_5555_5555_5555, 16'h0, 0, OUT_ZERO);
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].handle,
                      directed_rows[i].typed, directed_rows[i].want);
      drain_requests();

      snd_idle_pct = 74;
      rcv_idle_pct = 35;
      for (n = 0; n < 900; n++) begin
         if (n == 450) begin
            drain_requests();
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         if (n % 40 == 0)
            hot_base = ($urandom_range(0, 3) == 0)
                       ? int'($urandom_range(lpht_pkg::SLOTS - 8, lpht_pkg::SLOTS - 1))
                       : int'($urandom_range(0, lpht_pkg::SLOTS - 1));
         roll = int'($urandom_range(0, 99));
         if (roll < 2) begin
            send_request(lpht_pkg::REQ_CLEAR, {$urandom, $urandom}, 16'($urandom), 1,
                         OUT_ZERO);
            live_keys.delete();
         end else if (roll < 5) begin
            send_request(REQ_NOP, {$urandom, $urandom}, 16'($urandom), 1, OUT_ZERO);
         end else if (roll < 50) begin
            // some inserts repeat a stored key to build duplicate entries
            if (live_keys.size() > 0 && $urandom_range(0, 4) == 0)
               k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else if ($urandom_range(0, 7) == 0)
               k = {$urandom, $urandom};
            else
               k = hot_key(hot_base);
            live_keys.push_back(k);
            send_request(lpht_pkg::REQ_INSERT, k, 16'($urandom), 0, OUT_ZERO);
         end else begin
            if (live_keys.size() > 0 && $urandom_range(0, 9) < 7)
               k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else
               k = hot_key(hot_base);
            send_request(lpht_pkg::REQ_LOOKUP, k, 16'($urandom), 0, OUT_ZERO);
         end
      end
      drain_requests();
      repeat (16) @(posedge clock);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_slot_ram.sv
hw/rtl/linear_probe_hash_table.sv
sim/tb_linear_probe_hash_table.sv
